[sv/thrm_pkg.sv]
// ----------------------------------------------------------------------------
// thrm_pkg
// shared constants, types and calibration contents for the thermistor
// adc to temperature converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package thrm_pkg;

  localparam int ADC_BITS_DEF  = 10;
  localparam int TABLE_ENTRIES = 33;
  localparam int OHM_W         = 16;
  localparam int TEMP_W        = 11;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;

  localparam logic [PADDR_W-1:0] REG_SERIES_ADDR = 3'd0;
  localparam logic [OHM_W-1:0]   SERIES_RESET    = 16'd10000;
  localparam logic [OHM_W-1:0]   OHM_MAX         = 16'hffff;
  localparam logic [TEMP_W-1:0]  TEMP_MAX        = 11'h7ff;

  typedef struct packed {
    logic [15:0] ohms;
    logic [15:0] temp;
  } cal_entry_t;

  localparam cal_entry_t CAL_TABLE [TABLE_ENTRIES] = '{
    '{16'd65535, 16'd370},  '{16'd55046, 16'd400},  '{16'd42157, 16'd450},
    '{16'd32554, 16'd500},  '{16'd25339, 16'd550},  '{16'd19872, 16'd600},
    '{16'd15698, 16'd650},  '{16'd12488, 16'd700},  '{16'd10000, 16'd750},
    '{16'd8059,  16'd800},  '{16'd6535,  16'd850},  '{16'd5330,  16'd900},
    '{16'd4372,  16'd950},  '{16'd3605,  16'd1000}, '{16'd2989,  16'd1050},
    '{16'd2490,  16'd1100}, '{16'd2084,  16'd1150}, '{16'd1753,  16'd1200},
    '{16'd1481,  16'd1250}, '{16'd1256,  16'd1300}, '{16'd1070,  16'd1350},
    '{16'd915,   16'd1400}, '{16'd786,   16'd1450}, '{16'd677,   16'd1500},
    '{16'd586,   16'd1550}, '{16'd508,   16'd1600}, '{16'd443,   16'd1650},
    '{16'd387,   16'd1700}, '{16'd339,   16'd1750}, '{16'd298,   16'd1800},
    '{16'd262,   16'd1850}, '{16'd232,   16'd1900}, '{16'd206,   16'd1950}
  };

  localparam int TBL_AW = $clog2(TABLE_ENTRIES);
  localparam int IDX_W  = $clog2(TABLE_ENTRIES + 1);

endpackage

[sv/thermistor_adc_to_temperature.sv]
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature
// a zero code gives an out-of-range result with no division; else a serial
// division yields the resistance and 5 or 6 search reads find its interval,
// out of range below the last calibration point, else a second serial
// division interpolates; throughput: a request is taken only while idle,
// the next one while the result is shown, the receiver cannot stall
// reset: synchronous active-low, series resistance returns to 10000 ohms
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thermistor_adc_to_temperature #(
  parameter int ADC_BITS = thrm_pkg::ADC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ADC_BITS-1:0]           in_adc_code,
  output logic                          out_valid,
  output logic [thrm_pkg::TEMP_W-1:0]   out_temperature,
  output logic                          out_out_of_range,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [thrm_pkg::PADDR_W-1:0]  paddr,
  input  logic [thrm_pkg::PDATA_W-1:0]  pwdata,
  output logic [thrm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import thrm_pkg::*;

  localparam int NUM_W = OHM_W + ((ADC_BITS > TEMP_W) ? ADC_BITS : TEMP_W);
  localparam int P1_W  = OHM_W + ADC_BITS;
  localparam int P2_W  = OHM_W + TEMP_W;
  localparam logic [ADC_BITS-1:0] FULL = '1;
  localparam logic [IDX_W-1:0]    N_IDX = IDX_W'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0]    MID0  = IDX_W'((1 + TABLE_ENTRIES) / 2);
  localparam logic [TEMP_W-1:0]   LAST_TEMP = CAL_TABLE[TABLE_ENTRIES-1].temp[TEMP_W-1:0];

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL1 = 4'd1;
  localparam logic [3:0] ST_D1S  = 4'd2;
  localparam logic [3:0] ST_D1W  = 4'd3;
  localparam logic [3:0] ST_SRCH = 4'd4;
  localparam logic [3:0] ST_FA   = 4'd5;
  localparam logic [3:0] ST_FB   = 4'd6;
  localparam logic [3:0] ST_MUL2 = 4'd7;
  localparam logic [3:0] ST_D2S  = 4'd8;
  localparam logic [3:0] ST_D2W  = 4'd9;

  logic [3:0]          state_r, state_nxt;
  logic [OHM_W-1:0]    ser_r, ser_nxt;
  logic [ADC_BITS-1:0] code_r, code_nxt;
  logic [NUM_W-1:0]    prod_r, prod_nxt;
  logic [OHM_W-1:0]    res_r, res_nxt;
  logic [IDX_W-1:0]    lo_r, lo_nxt;
  logic [IDX_W-1:0]    hi_r, hi_nxt;
  logic [IDX_W-1:0]    mid_r, mid_nxt;
  logic [OHM_W-1:0]    hr_r, hr_nxt;
  logic [TEMP_W-1:0]   ht_r, ht_nxt;
  logic [OHM_W-1:0]    nd_r, nd_nxt;
  logic [TEMP_W-1:0]   dt_r, dt_nxt;
  logic [OHM_W-1:0]    span_r, span_nxt;
  logic                valid_r, valid_nxt;
  logic [TEMP_W-1:0]   temp_r, temp_nxt;
  logic                oor_r, oor_nxt;

  logic [P1_W-1:0]     p1;
  logic [P2_W-1:0]     p2;
  logic [TBL_AW-1:0]   rom_addr;
  cal_entry_t          rom_data;
  logic                div_start;
  logic [OHM_W-1:0]    div_den;
  logic                div_done;
  logic [NUM_W-1:0]    div_quot;
  logic                ge;
  logic [IDX_W-1:0]    lo_s, hi_s, mid_s;
  logic [TEMP_W:0]     tsum;
  logic                cfg_wr;

  thrm_rom u_rom (
    .clk   (clk),
    .addr  (rom_addr),
    .rdata (rom_data)
  );

  thrm_div #(
    .NUM_W (NUM_W),
    .DEN_W (OHM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign cfg_wr = psel && penable && pwrite && (paddr == REG_SERIES_ADDR);
  assign pready = 1'b1;
  assign prdata = (paddr == REG_SERIES_ADDR) ? PDATA_W'(ser_r) : '0;

  assign busy      = (state_r != ST_IDLE);
  assign div_start = (state_r == ST_D1S) || (state_r == ST_D2S);
  assign div_den   = (state_r == ST_D1S) ? OHM_W'(code_r) : span_r;

  always_comb begin
    p1 = P1_W'(ser_r) * P1_W'(FULL - code_r);
    p2 = P2_W'(nd_r) * P2_W'(dt_r);
    ge = res_r >= rom_data.ohms;
    lo_s = ge ? lo_r : (mid_r + 1'b1);
    hi_s = ge ? mid_r : hi_r;
    mid_s = IDX_W'((IDX_W + 1)'(lo_s) + (IDX_W + 1)'(hi_s) >> 1);
    tsum = {1'b0, ht_r} + {1'b0, div_quot[TEMP_W-1:0]};

    state_nxt = state_r;
    ser_nxt   = cfg_wr ? pwdata[OHM_W-1:0] : ser_r;
    code_nxt  = code_r;
    prod_nxt  = prod_r;
    res_nxt   = res_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    hr_nxt    = hr_r;
    ht_nxt    = ht_r;
    nd_nxt    = nd_r;
    dt_nxt    = dt_r;
    span_nxt  = span_r;
    valid_nxt = 1'b0;
    temp_nxt  = temp_r;
    oor_nxt   = oor_r;
    rom_addr  = mid_r[TBL_AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          code_nxt = in_adc_code;
          if (in_adc_code == '0) begin
            valid_nxt = 1'b1;
            temp_nxt  = LAST_TEMP;
            oor_nxt   = 1'b1;
          end else begin
            state_nxt = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        prod_nxt  = NUM_W'(p1);
        state_nxt = ST_D1S;
      end
      ST_D1S: begin
        state_nxt = ST_D1W;
      end
      ST_D1W: begin
        if (div_done) begin
          res_nxt   = (div_quot > NUM_W'(OHM_MAX)) ? OHM_MAX : div_quot[OHM_W-1:0];
          lo_nxt    = IDX_W'(1);
          hi_nxt    = N_IDX;
          mid_nxt   = MID0;
          rom_addr  = MID0[TBL_AW-1:0];
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        lo_nxt = lo_s;
        hi_nxt = hi_s;
        if (lo_s == hi_s) begin
          if (hi_s == N_IDX) begin
            valid_nxt = 1'b1;
            temp_nxt  = LAST_TEMP;
            oor_nxt   = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            mid_nxt   = lo_s;
            rom_addr  = TBL_AW'(lo_s - 1'b1);
            state_nxt = ST_FA;
          end
        end else begin
          mid_nxt  = mid_s;
          rom_addr = mid_s[TBL_AW-1:0];
        end
      end
      ST_FA: begin
        hr_nxt    = rom_data.ohms;
        ht_nxt    = rom_data.temp[TEMP_W-1:0];
        rom_addr  = mid_r[TBL_AW-1:0];
        state_nxt = ST_FB;
      end
      ST_FB: begin
        nd_nxt    = hr_r - res_r;
        dt_nxt    = rom_data.temp[TEMP_W-1:0] - ht_r;
        span_nxt  = hr_r - rom_data.ohms;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        prod_nxt  = NUM_W'(p2);
        state_nxt = ST_D2S;
      end
      ST_D2S: begin
        state_nxt = ST_D2W;
      end
      ST_D2W: begin
        if (div_done) begin
          valid_nxt = 1'b1;
          oor_nxt   = 1'b0;
          if ((div_quot > NUM_W'(TEMP_MAX)) || tsum[TEMP_W]) begin
            temp_nxt = TEMP_MAX;
          end else begin
            temp_nxt = tsum[TEMP_W-1:0];
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ser_r   <= SERIES_RESET;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ser_r   <= ser_nxt;
      valid_r <= valid_nxt;
    end
    code_r <= code_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    hr_r   <= hr_nxt;
    ht_r   <= ht_nxt;
    nd_r   <= nd_nxt;
    dt_r   <= dt_nxt;
    span_r <= span_nxt;
    temp_r <= temp_nxt;
    oor_r  <= oor_nxt;
  end

  assign out_valid        = valid_r;
  assign out_temperature  = temp_r;
  assign out_out_of_range = oor_r;

endmodule

[sv/thrm_rom.sv]
// ----------------------------------------------------------------------------
// thrm_rom
// calibration memory, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thrm_rom (
  input  logic                      clk,
  input  logic [thrm_pkg::TBL_AW-1:0] addr,
  output thrm_pkg::cal_entry_t      rdata
);
  import thrm_pkg::*;

  cal_entry_t mem [TABLE_ENTRIES];
  cal_entry_t rdata_r;

  always_comb begin
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      mem[k] = CAL_TABLE[k];
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

[sv/thrm_div.sv]
// ----------------------------------------------------------------------------
// thrm_div
// restoring radix-2 unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thrm_div #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  import thrm_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    rem_sh   = {rem_r, q_r[NUM_W-1]};
    ge       = rem_sh >= {1'b0, den_r};
    diff     = rem_sh - {1'b0, den_r};
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      cnt_nxt = CW'(NUM_W);
      q_nxt   = num;
      rem_nxt = '0;
      den_nxt = den;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CW'(1));
      q_nxt    = {q_r[NUM_W-2:0], ge};
      rem_nxt  = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
